// ===== sv/fhd_pkg.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder package
// Shared constants, status codes and the job record passed from front to back.
//------------------------------------------------------------------------------
package fhd_pkg;

	localparam int unsigned HEADER_LEN = 32;
	localparam int unsigned CNT_W = 17;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] MAGIC0 = 8'h52; // 'R'
	localparam logic [7:0] MAGIC1 = 8'h46; // 'F'
	localparam logic [7:0] MAGIC2 = 8'h41; // 'A'
	localparam logic [7:0] MAGIC3 = 8'h50; // 'P'

	localparam logic [2:0] REG_MAX_OBJ = 3'd0;
	localparam logic [2:0] REG_MAX_CHUNK = 3'd1;
	localparam logic [2:0] REG_VERSION = 3'd2;
	localparam logic [2:0] REG_KNOWN = 3'd3;
	localparam logic [2:0] REG_FIRST = 3'd4;
	localparam logic [2:0] REG_LAST = 3'd5;

	typedef enum logic [4:0] {
		ST_OK = 5'd0, ST_TRUNC = 5'd1, ST_MAGIC = 5'd2, ST_VERSION = 5'd3,
		ST_HDRLEN = 5'd4, ST_OBJBIG = 5'd5, ST_CNT0 = 5'd6, ST_IDX = 5'd7,
		ST_CHUNKBIG = 5'd8, ST_RESV = 5'd9, ST_FLAGS = 5'd10, ST_FIRST = 5'd11,
		ST_LAST = 5'd12, ST_RANGE = 5'd13, ST_COUNT = 5'd14, ST_CHUNKLEN = 5'd15,
		ST_SIZE = 5'd16
	} status_t;

	// One finished fragment as captured by the front end.
	typedef struct packed {
		logic [4:0]  early;      // status from checks that need no division
		logic [7:0]  flags;
		logic [31:0] epoch;
		logic [31:0] ident;
		logic [31:0] total;
		logic [15:0] idx;
		logic [15:0] cnt;
		logic [15:0] clen;
		logic [31:0] csum;
		logic [CNT_W-1:0] size;
	} job_t;

endpackage

// ===== sv/fhd_front.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder front end
// Captures header bytes, counts the fragment and runs the simple checks.
//------------------------------------------------------------------------------
module fhd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_fragment,
	input  logic [31:0]        max_obj,
	input  logic [15:0]        max_chunk,
	input  logic [7:0]         exp_ver,
	input  logic [7:0]         known_mask,
	input  logic [7:0]         first_mask,
	input  logic [7:0]         last_mask,
	output logic               job_valid,
	input  logic               job_full,
	output fhd_pkg::job_t      job
);

	logic [7:0] hdr_q [fhd_pkg::HEADER_LEN];
	logic [fhd_pkg::CNT_W-1:0] cnt_q;
	logic [fhd_pkg::CNT_W-1:0] size;
	logic acc;
	logic [7:0] hb [fhd_pkg::HEADER_LEN];
	logic [15:0] idx, cnt, clen, resv, hlen;
	logic [31:0] total;
	logic [7:0] flags;
	logic first_set, last_set;
	logic [4:0] st;

	assign in_stall = job_full;
	assign acc = in_valid && !job_full;
	assign size = (cnt_q == fhd_pkg::CNT_MAX) ? cnt_q : cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (acc && cnt_q < fhd_pkg::CNT_W'(fhd_pkg::HEADER_LEN))
			hdr_q[cnt_q[$clog2(fhd_pkg::HEADER_LEN)-1:0]] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (acc) begin
			cnt_q <= end_of_fragment ? '0 : size;
		end
	end

	// The final byte may still land in the header, so read through it.
	always_comb begin
		for (int i = 0; i < fhd_pkg::HEADER_LEN; i++)
			hb[i] = (cnt_q == fhd_pkg::CNT_W'(i)) ? rx_byte : hdr_q[i];
	end

	assign flags = hb[5];
	assign hlen = {hb[7], hb[6]};
	assign total = {hb[19], hb[18], hb[17], hb[16]};
	assign idx = {hb[21], hb[20]};
	assign cnt = {hb[23], hb[22]};
	assign clen = {hb[25], hb[24]};
	assign resv = {hb[27], hb[26]};
	assign first_set = (flags & first_mask) != 8'd0;
	assign last_set = (flags & last_mask) != 8'd0;

	always_comb begin
		if (size < fhd_pkg::CNT_W'(fhd_pkg::HEADER_LEN)) st = fhd_pkg::ST_TRUNC;
		else if (hb[0] != fhd_pkg::MAGIC0 || hb[1] != fhd_pkg::MAGIC1 ||
			hb[2] != fhd_pkg::MAGIC2 || hb[3] != fhd_pkg::MAGIC3) st = fhd_pkg::ST_MAGIC;
		else if (hb[4] != exp_ver) st = fhd_pkg::ST_VERSION;
		else if (hlen != 16'(fhd_pkg::HEADER_LEN)) st = fhd_pkg::ST_HDRLEN;
		else if (total > max_obj) st = fhd_pkg::ST_OBJBIG;
		else if (cnt == 16'd0) st = fhd_pkg::ST_CNT0;
		else if (idx >= cnt) st = fhd_pkg::ST_IDX;
		else if (clen > max_chunk) st = fhd_pkg::ST_CHUNKBIG;
		else if (resv != 16'd0) st = fhd_pkg::ST_RESV;
		else if ((flags & ~known_mask) != 8'd0) st = fhd_pkg::ST_FLAGS;
		else if (first_set != (idx == 16'd0)) st = fhd_pkg::ST_FIRST;
		else if (last_set != (idx == cnt - 16'd1)) st = fhd_pkg::ST_LAST;
		else st = fhd_pkg::ST_OK;
	end

	assign job_valid = acc && end_of_fragment;
	always_comb begin
		job.early = st;
		job.flags = flags;
		job.epoch = {hb[11], hb[10], hb[9], hb[8]};
		job.ident = {hb[15], hb[14], hb[13], hb[12]};
		job.total = total;
		job.idx = idx;
		job.cnt = cnt;
		job.clen = clen;
		job.csum = {hb[31], hb[30], hb[29], hb[28]};
		job.size = size;
	end

endmodule

// ===== sv/fhd_queue.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder job queue
// Two-entry queue between the front end and the checking back end.
//------------------------------------------------------------------------------
module fhd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          full,
	input  fhd_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_take,
	output fhd_pkg::job_t rd_data
);

	fhd_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] n_q;

	assign full = n_q == 2'd2;
	assign rd_valid = n_q != 2'd0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			n_q <= 2'd0;
		end else begin
			if (wr_valid) wp_q <= ~wp_q;
			if (rd_take) rp_q <= ~rp_q;
			n_q <= n_q + {1'b0, wr_valid} - {1'b0, rd_take};
		end
	end

endmodule

// ===== sv/fhd_back.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder back end
// Runs the division based count and chunk checks and holds the result.
//------------------------------------------------------------------------------
module fhd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_take,
	input  fhd_pkg::job_t job,
	input  logic [15:0]   max_chunk,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [4:0]    status,
	output logic [7:0]    flag_bits,
	output logic [31:0]   epoch_word,
	output logic [31:0]   object_ident,
	output logic [31:0]   object_length,
	output logic [15:0]   frag_index,
	output logic [15:0]   frag_count,
	output logic [15:0]   payload_length,
	output logic [31:0]   object_checksum
);

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_CHK, S_OUT} state_t;

	state_t state_q;
	fhd_pkg::job_t job_q;
	logic [32:0] num_q;   // total + mc - 1, restoring division dividend
	logic [16:0] rem_q;
	logic [5:0]  bit_q;
	logic [32:0] quo_q;
	logic [31:0] off_q;
	logic [4:0]  st;
	logic [17:0] trial;
	logic [16:0] rem_sh;
	logic [32:0] exp_chunk;
	logic [32:0] remaining;

	assign rem_sh = {rem_q[15:0], num_q[bit_q]};
	assign trial = {1'b0, rem_sh} - {2'b0, max_chunk};
	assign job_take = state_q == S_IDLE && job_valid;
	assign remaining = ({1'b0, job_q.total} > {1'b0, off_q}) ?
		{1'b0, job_q.total} - {1'b0, off_q} : 33'd0;
	assign exp_chunk = (job_q.total == 32'd0) ? 33'd0 :
		(remaining > {17'd0, max_chunk}) ? {17'd0, max_chunk} : remaining;

	always_comb begin
		if (job_q.early != fhd_pkg::ST_OK) st = job_q.early;
		else if (job_q.total != 32'd0 && max_chunk == 16'd0) st = fhd_pkg::ST_RANGE;
		else if (job_q.total != 32'd0 && quo_q > 33'd65535) st = fhd_pkg::ST_RANGE;
		else if (job_q.total == 32'd0 && job_q.cnt != 16'd1) st = fhd_pkg::ST_COUNT;
		else if (job_q.total != 32'd0 && quo_q != {17'd0, job_q.cnt}) st = fhd_pkg::ST_COUNT;
		else if ({17'd0, job_q.clen} != exp_chunk) st = fhd_pkg::ST_CHUNKLEN;
		else if (job_q.size != {1'b0, job_q.clen} + 17'(fhd_pkg::HEADER_LEN))
			st = fhd_pkg::ST_SIZE;
		else st = fhd_pkg::ST_OK;
	end

	// Ceiling division runs one quotient bit per cycle over 33 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q <= job;
						num_q <= {1'b0, job.total} + {17'd0, max_chunk} - 33'd1;
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= 6'd32;
						state_q <= (job.early != fhd_pkg::ST_OK || max_chunk == 16'd0 ||
							job.total == 32'd0) ? S_MUL : S_DIV;
					end
				end
				S_DIV: begin
					if (!trial[17]) begin
						rem_q <= trial[16:0];
						quo_q <= {quo_q[31:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[31:0], 1'b0};
					end
					if (bit_q == 6'd0) state_q <= S_MUL;
					else bit_q <= bit_q - 6'd1;
				end
				S_MUL: begin
					off_q <= job_q.idx * max_chunk;
					state_q <= S_CHK;
				end
				S_CHK: begin
					status <= st;
					if (st == fhd_pkg::ST_OK) begin
						flag_bits <= job_q.flags;
						epoch_word <= job_q.epoch;
						object_ident <= job_q.ident;
						object_length <= job_q.total;
						frag_index <= job_q.idx;
						frag_count <= job_q.cnt;
						payload_length <= job_q.clen;
						object_checksum <= job_q.csum;
					end else begin
						flag_bits <= '0;
						epoch_word <= '0;
						object_ident <= '0;
						object_length <= '0;
						frag_index <= '0;
						frag_count <= '0;
						payload_length <= '0;
						object_checksum <= '0;
					end
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/fragment_header_decoder.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder
// Accepts one fragment byte per cycle unless the job queue is full; checks the header at fragment end.
//------------------------------------------------------------------------------
// Bytes are taken one per cycle; the front end never stalls unless the job queue is full.
// out_valid rises after the final byte passes the queue hand-off, 33-step serial divider,
// multiply state and check state; a header that fails an early check, or has a zero object
// length or zero max chunk, skips the divider. The back end takes a new job only from idle,
// after its result is accepted; with no output stall, fragments of 37 or more bytes sustain
// one byte per cycle. Reset clears counter, queue and back-end state, sets config defaults.
module fragment_header_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_fragment,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  status,
	output logic [7:0]  flag_bits,
	output logic [31:0] epoch_word,
	output logic [31:0] object_ident,
	output logic [31:0] object_length,
	output logic [15:0] frag_index,
	output logic [15:0] frag_count,
	output logic [15:0] payload_length,
	output logic [31:0] object_checksum
);

	logic [31:0] max_obj_q;
	logic [15:0] max_chunk_q;
	logic [7:0] ver_q, known_q, first_q, last_q;
	logic fj_valid, q_full, b_valid, b_take;
	fhd_pkg::job_t fj, bj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_obj_q <= 32'd16777216;
			max_chunk_q <= 16'd1024;
			ver_q <= 8'd1;
			known_q <= 8'd3;
			first_q <= 8'd1;
			last_q <= 8'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fhd_pkg::REG_MAX_OBJ: max_obj_q <= cfg_data;
				fhd_pkg::REG_MAX_CHUNK: max_chunk_q <= cfg_data[15:0];
				fhd_pkg::REG_VERSION: ver_q <= cfg_data[7:0];
				fhd_pkg::REG_KNOWN: known_q <= cfg_data[7:0];
				fhd_pkg::REG_FIRST: first_q <= cfg_data[7:0];
				fhd_pkg::REG_LAST: last_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	fhd_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .rx_byte, .end_of_fragment,
		.max_obj(max_obj_q), .max_chunk(max_chunk_q), .exp_ver(ver_q),
		.known_mask(known_q), .first_mask(first_q), .last_mask(last_q),
		.job_valid(fj_valid), .job_full(q_full), .job(fj)
	);

	fhd_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .full(q_full), .wr_data(fj),
		.rd_valid(b_valid), .rd_take(b_take), .rd_data(bj)
	);

	fhd_back u_back (
		.clk, .arst_n, .job_valid(b_valid), .job_take(b_take), .job(bj),
		.max_chunk(max_chunk_q), .out_valid, .out_stall, .status, .flag_bits,
		.epoch_word, .object_ident, .object_length, .frag_index, .frag_count,
		.payload_length, .object_checksum
	);

endmodule

// ===== sv/fhd_checker.sv =====
//------------------------------------------------------------------------------
// Fragment header decoder checker
// Port level properties of the decoder, bound to the top level.
//------------------------------------------------------------------------------
module fhd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  status,
	input logic [7:0]  flag_bits,
	input logic [31:0] object_length
);

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 5'd16) else $error("status out of range");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 5'd0 |-> flag_bits == 8'd0 && object_length == 32'd0)
		else $error("fields not cleared on error");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status))
		else $error("stalled result changed");

endmodule

bind fragment_header_decoder fhd_checker u_fhd_checker (
	.clk, .arst_n, .out_valid, .out_stall, .status, .flag_bits, .object_length
);
